FILE: rtl/urb_pkg.sv
// Shared codes, types and a helper function of the UART register block.
`default_nettype none
package urb_pkg;

  localparam int RX_FIFO_DEPTH_DEFAULT = 16;

  // Kinds of input word.
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_RX_BYTE = 2'd2;
  localparam logic [1:0] ACT_TX_DONE = 2'd3;

  // Register offsets.
  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam int LCR_DLAB_BIT = 7;

  // Interrupt identification codes, highest priority first.
  localparam logic [3:0] IIR_LINE_STATUS = 4'h6;
  localparam logic [3:0] IIR_RX_DATA     = 4'h4;
  localparam logic [3:0] IIR_THR_EMPTY   = 4'h2;
  localparam logic [3:0] IIR_NONE        = 4'h1;
  localparam logic [1:0] IIR_FIFO_MARK   = 2'b11;

  // Interrupt enable bits.
  localparam int IER_RX_DATA_BIT = 0;
  localparam int IER_THRE_BIT    = 1;
  localparam int IER_LINE_BIT    = 2;

  // One result word as it leaves the update logic.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        from_mem;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic [15:0] divisor;
  } urb_res_t;

  function automatic logic [3:0] urb_iir_id(input logic [3:0] ie, input logic [3:0] errs,
                                            input logic rx_nonempty, input logic thre);
    logic [3:0] id;
    if (ie[IER_LINE_BIT] && (errs != 4'd0)) begin
      id = IIR_LINE_STATUS;
    end else if (ie[IER_RX_DATA_BIT] && rx_nonempty) begin
      id = IIR_RX_DATA;
    end else if (ie[IER_THRE_BIT] && thre) begin
      id = IIR_THR_EMPTY;
    end else begin
      id = IIR_NONE;
    end
    return id;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/urb_fifo_mem.sv
// Receive FIFO storage: one write port, one registered read port.
`default_nettype none
module urb_fifo_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/urb_core.sv
// Register file state and its per-word update logic.
`default_nettype none
module urb_core
  import urb_pkg::*;
#(
  parameter int DEPTH = RX_FIFO_DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    action,
  input  wire logic [2:0]    reg_index,
  input  wire logic [7:0]    write_data,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [2:0]    rx_errors,
  output urb_res_t           res,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [7:0]         mem_wr_data,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0] rx_head, rx_head_next;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [7:0]    tx_hold, tx_hold_next;
  logic          tx_hold_full, tx_hold_full_next;
  logic          shifter_busy, shifter_busy_next;
  logic          thre_pending, thre_pending_next;
  logic [3:0]    line_errors, line_errors_next;
  logic [3:0]    int_enable, int_enable_next;
  logic [7:0]    line_control, line_control_next;
  logic [4:0]    modem_control, modem_control_next;
  logic [7:0]    scratch, scratch_next;
  logic [7:0]    divisor_low, divisor_low_next;
  logic [7:0]    divisor_high, divisor_high_next;
  logic          fifo_enabled, fifo_enabled_next;

  logic          dlab;
  logic          rx_nonempty;
  logic [3:0]    iir_cur;
  logic [3:0]    rx_flags;
  logic [CW-1:0] rx_cap;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] head_inc;
  logic          wr_req;
  logic          rd_req;

  assign dlab        = line_control[LCR_DLAB_BIT];
  assign rx_nonempty = (rx_count != '0);
  assign iir_cur     = urb_iir_id(int_enable, line_errors, rx_nonempty, thre_pending);
  assign rx_flags    = {rx_errors, 1'b0};
  assign rx_cap      = fifo_enabled ? CW'(DEPTH) : CW'(1);
  assign head_inc    = (rx_head == AW'(DEPTH - 1)) ? '0 : rx_head + AW'(1);

  // Head plus count stays below twice the depth, so one subtract wraps it.
  always_comb begin
    tail_sum = SW'(rx_head) + SW'(rx_count);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_addr = tail_sum[AW-1:0];
  end

  always_comb begin
    rx_head_next       = rx_head;
    rx_count_next      = rx_count;
    tx_hold_next       = tx_hold;
    tx_hold_full_next  = tx_hold_full;
    shifter_busy_next  = shifter_busy;
    thre_pending_next  = thre_pending;
    line_errors_next   = line_errors;
    int_enable_next    = int_enable;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    scratch_next       = scratch;
    divisor_low_next   = divisor_low;
    divisor_high_next  = divisor_high;
    fifo_enabled_next  = fifo_enabled;
    res                = '0;
    wr_req             = 1'b0;
    rd_req             = 1'b0;
    mem_wr_addr        = tail_addr;

    unique case (action)
      ACT_READ: begin
        unique case (reg_index)
          REG_RBR_THR: begin
            if (dlab) begin
              res.read_data = divisor_low;
            end else if (rx_nonempty) begin
              rd_req        = 1'b1;
              res.from_mem  = 1'b1;
              rx_head_next  = head_inc;
              rx_count_next = rx_count - CW'(1);
            end
          end
          REG_IER: res.read_data = dlab ? divisor_high : {4'd0, int_enable};
          REG_IIR_FCR: begin
            res.read_data = {(fifo_enabled ? IIR_FIFO_MARK : 2'b00), 2'b00, iir_cur};
            if (iir_cur == IIR_THR_EMPTY) begin
              thre_pending_next = 1'b0;
            end
          end
          REG_LCR: res.read_data = line_control;
          REG_MCR: res.read_data = {3'd0, modem_control};
          REG_LSR: begin
            res.read_data = {fifo_enabled && (line_errors[3:1] != 3'd0),
                             !tx_hold_full && !shifter_busy,
                             !tx_hold_full,
                             line_errors,
                             rx_nonempty};
            line_errors_next = 4'd0;
          end
          REG_MSR: res.read_data = 8'd0;
          REG_SCR: res.read_data = scratch;
          default: res.read_data = 8'd0;
        endcase
      end
      ACT_WRITE: begin
        unique case (reg_index)
          REG_RBR_THR: begin
            if (dlab) begin
              divisor_low_next = write_data;
            end else if (!shifter_busy && !tx_hold_full) begin
              shifter_busy_next = 1'b1;
              res.tx_valid      = 1'b1;
              res.tx_byte       = write_data;
              thre_pending_next = 1'b1;
            end else begin
              tx_hold_next      = write_data;
              tx_hold_full_next = 1'b1;
              thre_pending_next = 1'b0;
            end
          end
          REG_IER: begin
            if (dlab) begin
              divisor_high_next = write_data;
            end else begin
              if (write_data[IER_THRE_BIT] && !int_enable[IER_THRE_BIT] && !tx_hold_full) begin
                thre_pending_next = 1'b1;
              end
              int_enable_next = write_data[3:0];
            end
          end
          REG_IIR_FCR: begin
            if ((write_data[0] != fifo_enabled) || write_data[1]) begin
              rx_head_next  = '0;
              rx_count_next = '0;
            end
            fifo_enabled_next = write_data[0];
            if (write_data[2] && tx_hold_full) begin
              tx_hold_full_next = 1'b0;
              thre_pending_next = 1'b1;
            end
          end
          REG_LCR: line_control_next  = write_data;
          REG_MCR: modem_control_next = write_data[4:0];
          REG_SCR: scratch_next       = write_data;
          default: ;
        endcase
      end
      ACT_RX_BYTE: begin
        if (rx_count < rx_cap) begin
          wr_req           = 1'b1;
          rx_count_next    = rx_count + CW'(1);
          line_errors_next = line_errors | rx_flags;
        end else begin
          // Overrun: without FIFOs the new byte replaces the held one.
          line_errors_next = line_errors | 4'b0001;
          if (!fifo_enabled) begin
            wr_req           = 1'b1;
            mem_wr_addr      = rx_head;
            line_errors_next = line_errors | 4'b0001 | rx_flags;
          end
        end
      end
      ACT_TX_DONE: begin
        if (shifter_busy) begin
          if (tx_hold_full) begin
            res.tx_valid      = 1'b1;
            res.tx_byte       = tx_hold;
            tx_hold_full_next = 1'b0;
            thre_pending_next = 1'b1;
          end else begin
            shifter_busy_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    res.irq     = urb_iir_id(int_enable_next, line_errors_next, rx_count_next != '0,
                             thre_pending_next) != IIR_NONE;
    res.divisor = {divisor_high_next, divisor_low_next};
  end

  assign mem_wr_en   = accept && wr_req;
  assign mem_wr_data = rx_byte;
  assign mem_rd_en   = accept && rd_req;
  assign mem_rd_addr = rx_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_count      <= '0;
      tx_hold       <= 8'd0;
      tx_hold_full  <= 1'b0;
      shifter_busy  <= 1'b0;
      thre_pending  <= 1'b0;
      line_errors   <= 4'd0;
      int_enable    <= 4'd0;
      line_control  <= 8'd0;
      modem_control <= 5'd0;
      scratch       <= 8'd0;
      divisor_low   <= 8'd0;
      divisor_high  <= 8'd0;
      fifo_enabled  <= 1'b0;
    end else if (accept) begin
      rx_head       <= rx_head_next;
      rx_count      <= rx_count_next;
      tx_hold       <= tx_hold_next;
      tx_hold_full  <= tx_hold_full_next;
      shifter_busy  <= shifter_busy_next;
      thre_pending  <= thre_pending_next;
      line_errors   <= line_errors_next;
      int_enable    <= int_enable_next;
      line_control  <= line_control_next;
      modem_control <= modem_control_next;
      scratch       <= scratch_next;
      divisor_low   <= divisor_low_next;
      divisor_high  <= divisor_high_next;
      fifo_enabled  <= fifo_enabled_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(DEPTH))
    else $error("receive count exceeds FIFO depth");

  a_single_when_off: assert property (@(posedge clk) disable iff (rst)
    !fifo_enabled |-> (rx_count <= CW'(1)))
    else $error("more than one byte held with FIFOs disabled");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(rx_head) < CW'(DEPTH))
    else $error("receive head out of range");

  a_tx_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && res.tx_valid) |=> shifter_busy)
    else $error("byte sent to shifter without marking it busy");

  a_hold_needs_busy: assert property (@(posedge clk) disable iff (rst)
    tx_hold_full |-> shifter_busy)
    else $error("holding register full while shifter idle");

endmodule
`default_nettype wire

FILE: rtl/urb_pipe.sv
// Two-stage result pipeline: memory read stage and output register.
`default_nettype none
module urb_pipe
  import urb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             accept,
  input  wire urb_res_t    res,
  input  wire logic [7:0]  mem_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             irq,
  output logic [15:0]      divisor
);

  logic     s1_valid;
  urb_res_t s1_res;
  logic     s2_valid;
  logic     s1_advance;

  assign s1_advance = !s2_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;
  assign out_valid  = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= accept;
      end
      if (s1_advance) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_advance && s1_valid) begin
      read_data <= s1_res.from_mem ? mem_data : s1_res.read_data;
      tx_valid  <= s1_res.tx_valid;
      tx_byte   <= s1_res.tx_byte;
      irq       <= s1_res.irq;
      divisor   <= s1_res.divisor;
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !out_ready) |=> (s1_valid && s2_valid))
    else $error("pipeline lost a word while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !out_ready) |-> !accept)
    else $error("word accepted into a full pipeline");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance) |=> s2_valid)
    else $error("result stage did not take the advancing word");

endmodule
`default_nettype wire

FILE: rtl/uart_8250_register_block.sv
// Top level of the 8250/16550-style UART register block.
`default_nettype none
// This block holds the programmer-visible registers of an 8250/16550-style
// UART: RBR/THR, IER, IIR/FCR, LCR, MCR, LSR, MSR and SCR at offsets 0 to 7,
// with the divisor latches in place of offsets 0 and 1 while LCR bit 7 is set.
// Each input word is a bus read, a bus write, a byte received from the serial
// line with its parity, framing and break flags, or a notice that the transmit
// shifter has finished its byte; every input word produces exactly one output
// word carrying the read data (zero unless a read), a byte for the transmit
// shifter when one is launched, the interrupt request after the word, and the
// current 16-bit baud divisor. The receive FIFO lives in a synchronous memory
// of RX_FIFO_DEPTH bytes (one byte of it is used while FIFOs are disabled);
// all other state is in flip-flops and is updated in the cycle a word is
// accepted. The block takes one word per clock cycle unless a stalled output
// holds it back. A result passes through the FIFO memory read stage and then
// the output register, so a stalled output still leaves room for one more
// input word before in_ready drops. Because each word's FIFO write lands at
// the edge that accepts it, a later read of the same entry always sees it,
// and no bypass is needed. The FIFO memory is not cleared at reset; only
// entries that were written are ever read.
module uart_8250_register_block
  import urb_pkg::*;
#(
  parameter int RX_FIFO_DEPTH = RX_FIFO_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [2:0]  reg_index,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [2:0]  rx_errors,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             irq,
  output logic [15:0]      divisor
);

  localparam int AW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;

  logic          accept;
  urb_res_t      res;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  // Register state and the update for the word being accepted.
  urb_core #(
    .DEPTH (RX_FIFO_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .rx_byte     (rx_byte),
    .rx_errors   (rx_errors),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr)
  );

  // Receive FIFO storage.
  urb_fifo_mem #(
    .DEPTH (RX_FIFO_DEPTH)
  ) u_fifo_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Handshake and result staging.
  urb_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accept    (accept),
    .res       (res),
    .mem_data  (mem_rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .irq       (irq),
    .divisor   (divisor)
  );

endmodule
`default_nettype wire
